@@ sv/dmf_pkg.sv @@
// Package for the mark FIFO with near-duplicate suppression.
// Holds sizes, mark record, compare result type and codes; no dependencies.
package dmf_pkg;

    localparam int MAX_MARKS  = 512;
    localparam int MARK_TYPES = 8;

    localparam int SLOT_W    = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int COUNT_W   = $clog2(MAX_MARKS + 1);
    localparam int TYPE_W    = (MARK_TYPES > 1) ? $clog2(MARK_TYPES) : 1;
    localparam int POS_W     = 24;
    localparam int RAD_W     = 16;
    localparam int LIM_W     = RAD_W - 2;
    localparam int IN_TYPE_W = 8;
    localparam int OUT_CNT_W = 10;

    localparam logic [1:0] OUTCOME_STORED  = 2'd0;
    localparam logic [1:0] OUTCOME_DROPPED = 2'd1;
    localparam logic [1:0] OUTCOME_EVICTED = 2'd2;
    localparam logic [1:0] OUTCOME_CLEARED = 2'd3;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic REG_DEDUP_ENABLE = 1'b0;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [RAD_W-1:0]  radius;
        logic [TYPE_W-1:0] mtype;
    } mark_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } cmp_t;

endpackage

@@ sv/dmf_store.sv @@
// Mark ring storage: one write port, one read port with registered data.
// Depends on dmf_pkg.
module dmf_store
    import dmf_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  mark_t             wr_data,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output mark_t             rd_data
);

    mark_t mem [MAX_MARKS];
    mark_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/dmf_match.sv @@
// Near-duplicate compare unit, one stored mark per cycle, registered result.
// Depends on dmf_pkg.
module dmf_match
    import dmf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  mark_t            new_mark,
    input  logic [LIM_W-1:0] limit,
    input  mark_t            entry,
    input  logic             entry_valid,
    output cmp_t             result
);

    logic [POS_W:0] dx, dy, adx, ady;
    logic [RAD_W:0] dr, adr;
    logic           near;
    cmp_t           result_reg, result_next;

    always_comb begin
        dx  = {new_mark.x[POS_W-1], new_mark.x} - {entry.x[POS_W-1], entry.x};
        dy  = {new_mark.y[POS_W-1], new_mark.y} - {entry.y[POS_W-1], entry.y};
        dr  = {1'b0, new_mark.radius} - {1'b0, entry.radius};
        adx = dx[POS_W] ? (~dx + 1'b1) : dx;
        ady = dy[POS_W] ? (~dy + 1'b1) : dy;
        adr = dr[RAD_W] ? (~dr + 1'b1) : dr;
        near = (new_mark.mtype == entry.mtype)
            && (adx < (POS_W+1)'(limit))
            && (ady < (POS_W+1)'(limit))
            && (adr < (RAD_W+1)'(limit));
        result_next.valid = entry_valid;
        result_next.hit   = entry_valid & near;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_reg <= '0;
        end else begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ sv/dedup_mark_fifo.sv @@
// Top level of the mark FIFO: sequencer, ring pointers, APB register, streams.
// Depends on dmf_pkg, dmf_store, dmf_match.
//
//  channel  | dir | payload                                   | handshake
//  s_axis   | in  | tdata x,y,radius,type; tuser kind         | tvalid/tready
//  m_axis   | out | tdata outcome, stored_count               | tvalid/tready
//  apb      | in  | dedup_enable at byte address 0            | psel/penable
//
// Add with dedup on, store not empty: SCAN (one ring read per stored mark), DRAIN,
// COMMIT, RESULT. Add with dedup off or empty store: COMMIT, RESULT. Clear: RESULT.
// s_tready is high only in idle; an item is taken while a result still waits.
// A stalled result holds the sequencer before its result is loaded.
// Reset empties the ring at once; entries are never read before written.
module dedup_mark_fifo
    import dmf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // pos_x[23:0], pos_y[47:24], radius[63:48], mark_type[71:64]
    input  logic        s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // outcome[1:0], stored_count[11:2], zero[15:12]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {IDLE, SCAN, DRAIN, COMMIT, RESULT} state_t;

    state_t              state_reg, state_next;
    mark_t               new_reg, new_next;
    logic [LIM_W-1:0]    limit_reg, limit_next;
    logic                hit_reg, hit_next;
    logic [COUNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [SLOT_W-1:0]   scan_slot_reg, scan_slot_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [SLOT_W-1:0]   oldest_reg, oldest_next;
    logic [COUNT_W-1:0]  held_reg, held_next;
    logic [1:0]          outcome_reg, outcome_next;
    logic                dedup_reg, dedup_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;

    logic                wr_en, rd_en;
    logic [SLOT_W-1:0]   wr_addr;
    mark_t               rd_data, in_mark;
    cmp_t                cmp;
    logic [COUNT_W:0]    tail_sum;
    logic                cfg_wr;

    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        in_mark.x      = s_tdata[23:0];
        in_mark.y      = s_tdata[47:24];
        in_mark.radius = s_tdata[63:48];
        in_mark.mtype  = ({1'b0, s_tdata[71:64]} < (IN_TYPE_W+1)'(MARK_TYPES))
                       ? s_tdata[64 +: TYPE_W] : '0;
    end

    always_comb begin
        state_next     = state_reg;
        new_next       = new_reg;
        limit_next     = limit_reg;
        hit_next       = hit_reg | (cmp.valid & cmp.hit);
        scan_cnt_next  = scan_cnt_reg;
        scan_slot_next = scan_slot_reg;
        rd_valid_next  = 1'b0;
        oldest_next    = oldest_reg;
        held_next      = held_reg;
        outcome_next   = outcome_reg;
        dedup_next     = dedup_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        tail_sum       = (COUNT_W+1)'(oldest_reg) + (COUNT_W+1)'(held_reg);
        wr_addr        = (tail_sum >= (COUNT_W+1)'(MAX_MARKS))
                       ? SLOT_W'(tail_sum - (COUNT_W+1)'(MAX_MARKS)) : SLOT_W'(tail_sum);

        if (cfg_wr && paddr[2] == REG_DEDUP_ENABLE) begin
            dedup_next = pwdata[0];
        end

        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    new_next      = in_mark;
                    limit_next    = s_tdata[63:50];
                    hit_next      = 1'b0;
                    scan_cnt_next = '0;
                    scan_slot_next = oldest_reg;
                    if (s_tuser == KIND_CLEAR) begin
                        held_next    = '0;
                        oldest_next  = '0;
                        outcome_next = OUTCOME_CLEARED;
                        state_next   = RESULT;
                    end else if (dedup_reg && held_reg != '0) begin
                        state_next = SCAN;
                    end else begin
                        state_next = COMMIT;
                    end
                end
            end
            SCAN: begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                scan_slot_next = (scan_slot_reg == SLOT_W'(MAX_MARKS - 1))
                               ? '0 : scan_slot_reg + 1'b1;
                if (scan_cnt_next == held_reg) begin
                    state_next = DRAIN;
                end
            end
            DRAIN: begin
                if (!rd_valid_reg && !cmp.valid) begin
                    state_next = COMMIT;
                end
            end
            COMMIT: begin
                if (hit_reg) begin
                    outcome_next = OUTCOME_DROPPED;
                end else if (held_reg >= COUNT_W'(MAX_MARKS)) begin
                    wr_en        = 1'b1;
                    wr_addr      = oldest_reg;
                    oldest_next  = (oldest_reg == SLOT_W'(MAX_MARKS - 1))
                                 ? '0 : oldest_reg + 1'b1;
                    outcome_next = OUTCOME_EVICTED;
                end else begin
                    wr_en        = 1'b1;
                    held_next    = held_reg + 1'b1;
                    outcome_next = OUTCOME_STORED;
                end
                state_next = RESULT;
            end
            RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, OUT_CNT_W'(held_reg), outcome_reg};
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            rd_valid_reg <= 1'b0;
            oldest_reg   <= '0;
            held_reg     <= '0;
            dedup_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            oldest_reg   <= oldest_next;
            held_reg     <= held_next;
            dedup_reg    <= dedup_next;
            m_tvalid_reg <= m_tvalid_next;
            hit_reg      <= hit_next;
        end
        new_reg       <= new_next;
        limit_reg     <= limit_next;
        scan_cnt_reg  <= scan_cnt_next;
        scan_slot_reg <= scan_slot_next;
        outcome_reg   <= outcome_next;
        m_tdata_reg   <= m_tdata_next;
    end

    dmf_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_slot_reg),
        .rd_data (rd_data)
    );

    dmf_match u_match (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .new_mark    (new_reg),
        .limit       (limit_reg),
        .entry       (rd_data),
        .entry_valid (rd_valid_reg),
        .result      (cmp)
    );

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_DEDUP_ENABLE) ? {31'b0, dedup_reg} : 32'b0;

endmodule

@@ sv/dmf_checker.sv @@
// Port-level checks for dedup_mark_fifo, attached by bind.
// Depends on dmf_pkg and the top level's ports.
module dmf_checker
    import dmf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:2] <= OUT_CNT_W'(MAX_MARKS))
        else $error("stored count above capacity");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == OUTCOME_CLEARED |-> m_tdata[11:2] == '0)
        else $error("clear did not empty store");

    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == OUTCOME_EVICTED |-> m_tdata[11:2] == OUT_CNT_W'(MAX_MARKS))
        else $error("eviction with store not full");

endmodule

bind dedup_mark_fifo dmf_checker u_dmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
